FILE: hdl/sis_pkg.sv
// Shared types, codes and helpers for the sorted integer set.
package sis_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned OUT9_W = 9;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOCHG  = 2'd1,
    STS_FULL   = 2'd2,
    STS_RANGE  = 2'd3
  } status_t;

  localparam logic [1:0] WID_16 = 2'd0;
  localparam logic [1:0] WID_32 = 2'd1;
  localparam logic [1:0] WID_64 = 2'd2;

  localparam logic signed [VAL_W-1:0] S16_LO = -64'sd32768;
  localparam logic signed [VAL_W-1:0] S16_HI = 64'sd32767;
  localparam logic signed [VAL_W-1:0] S32_LO = -64'sd2147483648;
  localparam logic signed [VAL_W-1:0] S32_HI = 64'sd2147483647;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                    load;
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } row_ctl_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] rdata;
  } row_stat_t;

  function automatic logic [1:0] width_needed(input logic signed [VAL_W-1:0] v);
    logic [1:0] w;
    if (v >= S16_LO && v <= S16_HI) w = WID_16;
    else if (v >= S32_LO && v <= S32_HI) w = WID_32;
    else w = WID_64;
    return w;
  endfunction

endpackage

FILE: hdl/sis_if.sv
// Command and result channel interfaces of the sorted integer set.
interface sis_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [sis_pkg::VAL_W-1:0]    value;
  logic [sis_pkg::IDX_W-1:0]           index;

  modport source (output valid, cmd, value, index, input ready);
  modport sink   (input valid, cmd, value, index, output ready);
endinterface

interface sis_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic                                found;
  logic [sis_pkg::OUT9_W-1:0]          position;
  logic signed [sis_pkg::VAL_W-1:0]    read_value;
  logic [sis_pkg::OUT9_W-1:0]          count;
  logic [1:0]                          width_code;

  modport source (output valid, status, found, position, read_value, count, width_code,
                  input ready);
  modport sink   (input valid, status, found, position, read_value, count, width_code,
                  output ready);
endinterface

FILE: hdl/sorted_integer_set.sv
// Top level of the sorted integer set: command sequencing and result register.
//
//  channel  | dir | transaction                         | payload
//  in_ch    | in  | in_ch.valid & in_ch.ready           | cmd, value, index
//  out_ch   | out | out_ch.valid & out_ch.ready         | status, found, position,
//           |     |                                     | read_value, count, width_code
//
// For each command, the accept edge registers the compare of every cell against the
// value, and the apply edge applies the shift in the cell row and loads the result
// register. The shared broadcast to the row limits this to one command in flight. The
// apply cycle waits while an earlier result is still held.
// Reset clears the count, width code, occupancy bits and handshakes.
module sorted_integer_set #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sis_in_if.sink     in_ch,
  sis_out_if.source  out_ch
);
  import sis_pkg::*;

  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r;
  logic signed [VAL_W-1:0] value_r;
  logic [1:0]              need_r;
  logic                    idx_ok_r;
  logic [CNTW-1:0]         count_r, count_nxt;
  logic [1:0]              width_r, width_nxt;

  logic                    out_valid_r;
  status_t                 status_r, status_nxt;
  logic                    found_r, found_nxt;
  logic [OUT9_W-1:0]       pos_r, pos_nxt;
  logic signed [VAL_W-1:0] rdv_r, rdv_nxt;
  logic [OUT9_W-1:0]       cnt_out_r;

  row_ctl_t                ctl;
  row_stat_t               stat;
  logic [CNTW-1:0]         row_pos;

  logic                    accept;
  logic                    fire;
  logic                    full;
  logic                    do_ins;
  logic                    do_rem;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign full        = (count_r == CNTW'(CAPACITY));

  always_comb begin
    ctl.load  = accept;
    ctl.ins   = do_ins;
    ctl.rem   = do_rem;
    ctl.value = (state_r == ST_EXEC) ? value_r : in_ch.value;
    ctl.index = in_ch.index;
  end

  sis_row #(.CAPACITY(CAPACITY)) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat),
    .pos   (row_pos)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Decide the command outcome from the row flags.
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    status_nxt = STS_NOCHG;
    found_nxt  = 1'b0;
    pos_nxt    = '0;
    rdv_nxt    = '0;
    count_nxt  = count_r;
    width_nxt  = width_r;
    case (cmd_r) inside
      CMD_ADD: begin
        if (stat.hit) begin
          pos_nxt = OUT9_W'(row_pos);
        end else if (full) begin
          status_nxt = STS_FULL;
        end else begin
          do_ins     = fire;
          status_nxt = STS_OK;
          found_nxt  = 1'b1;
          pos_nxt    = OUT9_W'(row_pos);
          count_nxt  = count_r + 1'b1;
          if (need_r > width_r) width_nxt = need_r;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (stat.hit) begin
          status_nxt = STS_OK;
          found_nxt  = 1'b1;
          pos_nxt    = OUT9_W'(row_pos);
          if (cmd_r == CMD_REMOVE) begin
            do_rem    = fire;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        if (idx_ok_r) begin
          status_nxt = STS_OK;
          rdv_nxt    = stat.rdata;
        end else begin
          status_nxt = STS_RANGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      width_r     <= WID_16;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        width_r     <= width_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the command for the apply cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_ch.cmd);
      value_r  <= in_ch.value;
      need_r   <= width_needed(in_ch.value);
      idx_ok_r <= (32'(in_ch.index) < 32'(count_r));
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      pos_r     <= pos_nxt;
      rdv_r     <= rdv_nxt;
      cnt_out_r <= OUT9_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.found      = found_r;
  assign out_ch.position   = pos_r;
  assign out_ch.read_value = rdv_r;
  assign out_ch.count      = cnt_out_r;
  assign out_ch.width_code = width_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("element count beyond capacity");

  a_width_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> width_r >= $past(width_r))
    else $error("width code narrowed");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without an apply cycle");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !accept)
    else $error("command accepted while one is in flight");
`endif

endmodule

FILE: hdl/sis_cell.sv
// One slot of the sorted row: stored element, occupancy and compare flags.
module sis_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sis_pkg::row_ctl_t                ctl,
  input  logic signed [sis_pkg::VAL_W-1:0] left_data,
  input  logic                             left_ge,
  input  logic                             left_occ,
  input  logic signed [sis_pkg::VAL_W-1:0] right_data,
  input  logic                             right_occ,
  output logic signed [sis_pkg::VAL_W-1:0] data,
  output logic                             ge,
  output logic                             occ,
  output logic                             bnd,
  output logic                             hit,
  output logic signed [sis_pkg::VAL_W-1:0] rdata
);
  import sis_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic                    occ_r;
  logic                    ge_r;
  logic                    eq_r;
  logic                    sel_r;

  // Flags from the compare against the broadcast value.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ge_r  <= !(occ_r && (data_r < ctl.value));
      eq_r  <= occ_r && (data_r == ctl.value);
      sel_r <= occ_r && (32'(ctl.index) == POS);
    end
  end

  // Shift right on insert, left on remove, only at or above the boundary.
  always_ff @(posedge clk) begin
    if (ctl.ins && ge_r) begin
      data_r <= left_ge ? left_data : ctl.value;
    end else if (ctl.rem && ge_r) begin
      data_r <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.ins) begin
      occ_r <= left_occ;
    end else if (ctl.rem) begin
      occ_r <= right_occ;
    end
  end

  assign data  = data_r;
  assign ge    = ge_r;
  assign occ   = occ_r;
  assign bnd   = ge_r && !left_ge;
  assign hit   = bnd && eq_r;
  assign rdata = sel_r ? data_r : '0;

endmodule

FILE: hdl/sis_row.sv
// Chain of cells holding the sorted set, with the position and read reductions.
module sis_row #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF,
  localparam int unsigned PW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sis_pkg::row_ctl_t  ctl,
  output sis_pkg::row_stat_t stat,
  output logic [PW-1:0]      pos
);
  import sis_pkg::*;

  logic signed [VAL_W-1:0] data_w  [CAPACITY];
  logic signed [VAL_W-1:0] rdata_w [CAPACITY];
  logic [CAPACITY-1:0]     ge_w;
  logic [CAPACITY-1:0]     occ_w;
  logic [CAPACITY-1:0]     bnd_w;
  logic [CAPACITY-1:0]     hit_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] ld;
    logic                    lg;
    logic                    lo;
    logic signed [VAL_W-1:0] rd;
    logic                    ro;

    if (i == 0) begin : g_first
      assign ld = '0;
      assign lg = 1'b0;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign ld = data_w[i-1];
      assign lg = ge_w[i-1];
      assign lo = occ_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rd = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rd = data_w[i+1];
      assign ro = occ_w[i+1];
    end

    sis_cell #(.POS(i)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_data  (ld),
      .left_ge    (lg),
      .left_occ   (lo),
      .right_data (rd),
      .right_occ  (ro),
      .data       (data_w[i]),
      .ge         (ge_w[i]),
      .occ        (occ_w[i]),
      .bnd        (bnd_w[i]),
      .hit        (hit_w[i]),
      .rdata      (rdata_w[i])
    );
  end

  // At most one boundary and one selected cell, so OR-merging is exact.
  always_comb begin
    logic [PW-1:0]           pos_acc;
    logic signed [VAL_W-1:0] rd_acc;
    pos_acc = '0;
    rd_acc  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_acc = pos_acc | (bnd_w[i] ? PW'(i) : '0);
      rd_acc  = rd_acc | rdata_w[i];
    end
    pos        = pos_acc;
    stat.rdata = rd_acc;
    stat.hit   = |hit_w;
  end

endmodule

FILE: dv/sorted_integer_set_test.sv
// Self-checking testbench for the sorted integer set: directed and random commands checked against a predictor.
module sorted_integer_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sis_pkg::*;

  typedef logic signed [VAL_W-1:0] word_t;

  typedef struct {
    cmd_t             op;
    word_t            value;
    logic [IDX_W-1:0] index;
  } set_cmd_t;

  typedef struct {
    status_t           status;
    logic              found;
    logic [OUT9_W-1:0] position;
    word_t             read_value;
    logic [OUT9_W-1:0] count;
    logic [1:0]        width_code;
  } set_result_t;

  localparam int    SET_CAPACITY = CAPACITY_DEF;
  localparam int    FILL_N       = 280;
  localparam int    CYCLE_LIMIT  = 200000;
  localparam word_t VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
  localparam word_t VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};

  logic clk;
  logic rst_n;

  sis_in_if  in_ch ();
  sis_out_if out_ch ();

  sorted_integer_set dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  set_cmd_t    pending_cmds[$];
  set_result_t expected_results[$];

  // Predicted contents of the set.
  word_t      set_members[SET_CAPACITY];
  int         set_size  = 0;
  logic [1:0] set_width = WID_16;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_off       = 1'b0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  word_t       fill_values[FILL_N];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [1:0] width_of(input word_t v);
    logic [1:0] w;
    if ((&v[VAL_W-1:15]) || !(|v[VAL_W-1:15])) w = WID_16;
    else if ((&v[VAL_W-1:31]) || !(|v[VAL_W-1:31])) w = WID_32;
    else w = WID_64;
    return w;
  endfunction

  // Number of members strictly below v.
  function automatic int rank_of(input word_t v);
    int p;
    p = 0;
    while (p < set_size && set_members[p] < v) p++;
    return p;
  endfunction

  function automatic void insert_member(input int slot, input word_t v);
    for (int i = set_size; i > slot; i--) set_members[i] = set_members[i-1];
    set_members[slot] = v;
    set_size++;
  endfunction

  function automatic set_result_t apply_command(input set_cmd_t c);
    set_result_t r;
    logic [1:0]  need;
    int          slot;
    logic        hit;
    r.status     = STS_NOCHG;
    r.found      = 1'b0;
    r.position   = '0;
    r.read_value = '0;
    need = width_of(c.value);
    case (c.op) inside
      CMD_ADD: begin
        if (need > set_width) begin
          // A wider value cannot be present: it lands at one end.
          if (set_size >= SET_CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            slot = c.value < 0 ? 0 : set_size;
            insert_member(slot, c.value);
            set_width  = need;
            r.status   = STS_OK;
            r.found    = 1'b1;
            r.position = OUT9_W'(slot);
          end
        end else begin
          slot = rank_of(c.value);
          hit  = slot < set_size && set_members[slot] == c.value;
          if (hit) begin
            r.position = OUT9_W'(slot);
          end else if (set_size >= SET_CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            insert_member(slot, c.value);
            r.status   = STS_OK;
            r.found    = 1'b1;
            r.position = OUT9_W'(slot);
          end
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (need <= set_width) begin
          slot = rank_of(c.value);
          if (slot < set_size && set_members[slot] == c.value) begin
            if (c.op == CMD_REMOVE) begin
              for (int i = slot; i + 1 < set_size; i++) set_members[i] = set_members[i+1];
              set_size--;
            end
            r.status   = STS_OK;
            r.found    = 1'b1;
            r.position = OUT9_W'(slot);
          end
        end
      end
      default: begin
        if (c.index < set_size) begin
          r.status     = STS_OK;
          r.read_value = set_members[c.index];
        end else begin
          r.status = STS_RANGE;
        end
      end
    endcase
    r.count      = OUT9_W'(set_size);
    r.width_code = set_width;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    set_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transaction with no command outstanding");
      return;
    end
    want = expected_results.pop_front();
    check_field("status", out_ch.status, want.status);
    check_field("found", out_ch.found, want.found);
    check_field("position", out_ch.position, want.position);
    check_field("read_value", out_ch.read_value, want.read_value);
    check_field("count", out_ch.count, want.count);
    check_field("width_code", out_ch.width_code, want.width_code);
  endtask

  // Driver: hold the payload while stalled, pick the next command once it moves.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.insert(expected_results.size(),
                                apply_command(pending_cmds.pop_front()));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd   <= pending_cmds[0].op;
          in_ch.value <= pending_cmds[0].value;
          in_ch.index <= pending_cmds[0].index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result transaction, stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_t op, input word_t v, input logic [IDX_W-1:0] idx);
    set_cmd_t c;
    c.op    = op;
    c.value = v;
    c.index = idx;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic word_t pick_value(input logic [1:0] w);
    word_t lo, hi, raw, v;
    lo  = w == WID_16 ? S16_LO : (w == WID_32 ? S32_LO : VAL_MIN);
    hi  = w == WID_16 ? S16_HI : (w == WID_32 ? S32_HI : VAL_MAX);
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = longint'($urandom_range(48)) - 24;
      5:             v = lo + $urandom_range(3);
      6:             v = hi - $urandom_range(3);
      default: begin
        if (w == WID_16) v = {{48{raw[15]}}, raw[15:0]};
        else if (w == WID_32) v = {{32{raw[31]}}, raw[31:0]};
        else v = raw;
      end
    endcase
    return v;
  endfunction

  // Value that needs the next wider code; force a high bit against the sign.
  function automatic word_t wider_value(input logic [1:0] w);
    word_t v;
    v = {$urandom, $urandom};
    if (w == WID_16) begin
      v = {{32{v[31]}}, v[31:0]};
      v[20] = ~v[63];
    end else begin
      v[40] = ~v[63];
    end
    return v;
  endfunction

  task automatic push_random(input int n, input logic [1:0] w);
    int               sel;
    cmd_t             op;
    word_t            v;
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      v   = pick_value(w);
      idx = $urandom_range(1) ? IDX_W'($urandom_range(255)) : IDX_W'($urandom_range(23));
      if (sel < 45) op = CMD_ADD;
      else if (sel < 70) op = CMD_REMOVE;
      else if (sel < 85) op = CMD_FIND;
      else op = CMD_GET;
      if (op != CMD_ADD && w != WID_64 && $urandom_range(9) == 0) v = wider_value(w);
      push_cmd(op, v, idx);
    end
  endtask

  task automatic shuffle_fill();
    int    j;
    word_t tmp;
    for (int i = FILL_N - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = fill_values[i];
      fill_values[i] = fill_values[j];
      fill_values[j] = tmp;
    end
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_ADD;
    in_ch.value  = '0;
    in_ch.index  = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extremes of the narrow width, absent and wide lookups.
    push_cmd(CMD_GET, 64'sd0, 8'd0);
    push_cmd(CMD_FIND, 64'sd0, 8'd0);
    push_cmd(CMD_REMOVE, 64'sd7, 8'd0);
    push_cmd(CMD_ADD, 64'sd0, 8'd0);
    push_cmd(CMD_ADD, 64'sd0, 8'd0);
    push_cmd(CMD_ADD, S16_HI, 8'd0);
    push_cmd(CMD_ADD, S16_LO, 8'd0);
    push_cmd(CMD_ADD, -64'sd1, 8'd0);
    push_cmd(CMD_FIND, S16_LO, 8'd0);
    push_cmd(CMD_FIND, S16_HI, 8'd0);
    push_cmd(CMD_GET, 64'sd0, 8'd0);
    push_cmd(CMD_GET, 64'sd0, 8'd3);
    push_cmd(CMD_GET, 64'sd0, 8'd4);
    push_cmd(CMD_GET, VAL_MIN, 8'd255);
    push_cmd(CMD_FIND, 64'sd40000, 8'd0);
    push_cmd(CMD_REMOVE, VAL_MIN, 8'd0);
    push_cmd(CMD_FIND, VAL_MAX, 8'd0);
    push_cmd(CMD_REMOVE, 64'sd0, 8'd0);
    push_cmd(CMD_REMOVE, 64'sd0, 8'd0);
    push_cmd(CMD_REMOVE, S16_HI, 8'd0);
    push_cmd(CMD_FIND, 64'sd5, 8'd0);
    wait_drained();

    set_idling(63, 0);
    push_random(250, WID_16);
    wait_drained();

    // Fill to capacity in random order, poke the full store, then empty it again.
    set_idling(0, 63);
    for (int k = 0; k < FILL_N; k++) fill_values[k] = longint'(k) * 100 - 14000;
    shuffle_fill();
    for (int k = 0; k < FILL_N; k++)
      push_cmd(CMD_ADD, fill_values[k], IDX_W'($urandom_range(255)));
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
    push_cmd(CMD_ADD, fill_values[0], 8'd0);
    push_cmd(CMD_ADD, S16_LO, 8'd0);
    push_cmd(CMD_ADD, 64'sd40000, 8'd0);
    push_cmd(CMD_ADD, VAL_MIN, 8'd0);
    push_cmd(CMD_GET, 64'sd0, 8'd255);
    push_cmd(CMD_FIND, fill_values[0], 8'd0);
    shuffle_fill();
    for (int k = 0; k < FILL_N; k++)
      push_cmd(CMD_REMOVE, fill_values[k], IDX_W'($urandom_range(255)));
    wait_drained();

    // Widen to 32 bits with a negative value, then run at that width.
    set_idling(6, 6);
    push_cmd(CMD_ADD, -64'sd40000, 8'd0);
    push_random(350, WID_32);
    wait_drained();

    // Widen to 64 bits with a positive value, then run over the whole range.
    set_idling(0, 0);
    push_cmd(CMD_ADD, VAL_MAX, 8'd0);
    push_random(400, WID_64);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/sis_pkg.sv
hdl/sis_if.sv
hdl/sis_cell.sv
hdl/sis_row.sv
hdl/sorted_integer_set.sv
dv/sorted_integer_set_test.sv
